// File: design/landmark_nearest_associate_average_unit_assert.svh
// Assertion macros shared by the landmark association design.
`ifndef LANDMARK_NEAREST_ASSOCIATE_AVERAGE_UNIT_ASSERT_SVH
`define LANDMARK_NEAREST_ASSOCIATE_AVERAGE_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define LNAA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define LNAA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LNAA_ASSERT_IMP(lbl, ante, cons, msg)
`define LNAA_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// File: design/lnaa_pkg.sv
// Types and constants of the landmark association unit.
`default_nettype none
package lnaa_pkg;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_MERGE_RADIUS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_OBS      = 2'd1;

  localparam logic [30:0] MERGE_RADIUS_RST = 31'd19661;
  localparam logic [15:0] MIN_OBS_RST      = 16'd3;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic               label;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic [15:0]        score;
    logic [15:0]        box_points;
    logic [15:0]        fit_points;
    logic [47:0]        obs_time;
  } in_item_t;

  typedef struct packed {
    logic [31:0]        landmark_id;
    logic               created;
    logic               dropped_full;
    logic [15:0]        obs_count;
    logic               confirmed;
    logic signed [31:0] mean_x;
    logic signed [31:0] mean_y;
    logic signed [31:0] mean_z;
    logic [15:0]        avg_score;
    logic [31:0]        revision;
  } out_item_t;

  typedef struct packed {
    logic [30:0] merge_radius;
    logic [15:0] confirm_count;
  } cfg_t;

  typedef struct packed {
    logic               label;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [15:0]        score;
    logic [15:0]        count;
    logic [15:0]        matched;
    logic [15:0]        inliers;
    logic [47:0]        first_time;
    logic [47:0]        last_time;
    logic [31:0]        id;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage
`default_nettype wire

// File: design/lnaa_ram.sv
// Generic single write port RAM with registered read.
`default_nettype none
module lnaa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule
`default_nettype wire

// File: design/lnaa_front.sv
// Input side: short item queue between the port and the back end.
`default_nettype none
module lnaa_front
  import lnaa_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_push,
  output logic          in_full,
  input  wire in_item_t in_item,
  input  wire logic     q_pop,
  output logic          q_empty,
  output in_item_t      q_item
);
  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  in_item_t        buf_r [QUEUE_DEPTH];
  logic [PW-1:0]   wp_r, rp_r;
  logic [CW-1:0]   cnt_r;
  logic            do_push, do_pop;

  assign in_full = (cnt_r == CW'(QUEUE_DEPTH));
  assign q_empty = (cnt_r == '0);
  assign do_push = in_push && !in_full;
  assign do_pop  = q_pop && !q_empty;
  assign q_item  = buf_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= (wp_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= (rp_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      buf_r[wp_r] <= in_item;
    end
  end
endmodule
`default_nettype wire

// File: design/lnaa_mean_lane.sv
// Running mean lane: (old*prev + obs) / (prev+1), bit-serial divide, truncating.
`default_nettype none
module lnaa_mean_lane
  import lnaa_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [32:0] old_val,
  input  wire logic signed [32:0] obs_val,
  input  wire logic [15:0]        prev,
  output logic                    done,
  output logic [31:0]             mean
);
  localparam int NW = 49;
  localparam int KW = $clog2(NW + 1);

  logic signed [49:0] prod_w, prod_r, num_w;
  logic signed [32:0] obs_r;
  logic [16:0]        div_r, rem_r, rem_nxt;
  logic [NW-1:0]      quo_r, mag_w, qfin_w;
  logic [17:0]        trial_w;
  logic               ge_w, neg_r;
  logic               ld_r, busy_r, done_r;
  logic [KW-1:0]      cnt_r;

  assign prod_w  = old_val * $signed({1'b0, prev});
  assign num_w   = prod_r + 50'(obs_r);
  assign mag_w   = num_w[49] ? NW'(50'sd0 - num_w) : num_w[NW-1:0];
  assign trial_w = {rem_r, quo_r[NW-1]};
  assign ge_w    = trial_w >= {1'b0, div_r};
  assign rem_nxt = ge_w ? 17'(trial_w - {1'b0, div_r}) : trial_w[16:0];
  assign qfin_w  = neg_r ? NW'(0) - quo_r : quo_r;
  assign mean    = qfin_w[31:0];
  assign done    = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ld_r   <= 1'b0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      ld_r   <= 1'b1;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else if (ld_r) begin
      ld_r   <= 1'b0;
      busy_r <= 1'b1;
      cnt_r  <= KW'(NW);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == KW'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      prod_r <= prod_w;
      obs_r  <= obs_val;
      div_r  <= {1'b0, prev} + 17'd1;
    end else if (ld_r) begin
      quo_r <= mag_w;
      rem_r <= '0;
      neg_r <= num_w[49];
    end else if (busy_r) begin
      quo_r <= {quo_r[NW-2:0], ge_w};
      rem_r <= rem_nxt;
    end
  end
endmodule
`default_nettype wire

// File: design/lnaa_back.sv
// Back end: table scan, nearest match, update or create, result register.
`default_nettype none
`include "landmark_nearest_associate_average_unit_assert.svh"
module lnaa_back
  import lnaa_pkg::*;
#(
  parameter int MAX_LANDMARKS = 64
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire cfg_t     cfg,
  output logic          q_pop,
  input  wire logic     q_empty,
  input  wire in_item_t q_item,
  input  wire logic     out_pop,
  output logic          out_empty,
  output out_item_t     out_item
);
  localparam int IW = $clog2(MAX_LANDMARKS);
  localparam int CW = $clog2(MAX_LANDMARKS + 1);

  typedef enum logic [7:0] {
    S_IDLE = 8'b00000001,
    S_RAD  = 8'b00000010,
    S_SCAN = 8'b00000100,
    S_RDB  = 8'b00001000,
    S_LAT  = 8'b00010000,
    S_DIV  = 8'b00100000,
    S_WR   = 8'b01000000,
    S_OUT  = 8'b10000000
  } state_t;

  state_t state_r, state_nxt;

  in_item_t            cur_r;
  entry_t              ent_r, rd_ent, new_ent;
  logic [ENTRY_W-1:0]  rd_raw;
  logic [IW-1:0]       raddr, waddr;
  logic                we;

  logic [MAX_LANDMARKS-1:0] valid_r;
  logic [31:0]   next_id_r, rev_r;
  logic [63:0]   best_d_r;
  logic          best_v_r, free_v_r;
  logic [IW-1:0] best_r, free_r;
  logic [CW-1:0] issue_r;
  logic          issue_w, scan_end;

  logic          p1_v_r, pa_v_r, pb_v_r, pa_el_r, pb_el_r;
  logic [IW-1:0] p1_idx_r, pa_idx_r, pb_idx_r;
  logic [31:0]   pa_ax_r, pa_ay_r;
  logic [63:0]   pb_sx_r, pb_sy_r, dist_w;
  logic [64:0]   sum_w;
  logic [32:0]   dx_w, dy_w, ndx_w, ndy_w;
  logic          el_w, hit_w;

  logic [3:0]    lane_done;
  logic [31:0]   qx, qy, qz, qs;
  logic          lane_start;

  logic [16:0]   reached_w;
  out_item_t     res_r, res_w, drop_w;
  logic          out_valid_r;

  assign rd_ent = entry_t'(rd_raw);

  lnaa_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_LANDMARKS)) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (new_ent),
    .raddr (raddr),
    .rdata (rd_raw)
  );

  assign issue_w  = (state_r == S_SCAN) && (issue_r != CW'(MAX_LANDMARKS));
  assign raddr    = (state_r == S_RDB) ? best_r : issue_r[IW-1:0];
  assign scan_end = (state_r == S_SCAN) && !issue_w && !p1_v_r && !pa_v_r && !pb_v_r;

  // stage A: eligibility and absolute planar differences
  assign el_w  = valid_r[p1_idx_r] && (rd_ent.label == cur_r.label);
  assign dx_w  = {rd_ent.x[31], rd_ent.x} - {cur_r.point_x[31], cur_r.point_x};
  assign dy_w  = {rd_ent.y[31], rd_ent.y} - {cur_r.point_y[31], cur_r.point_y};
  assign ndx_w = 33'd0 - dx_w;
  assign ndy_w = 33'd0 - dy_w;

  // stage C: saturating sum and compare
  assign sum_w  = {1'b0, pb_sx_r} + {1'b0, pb_sy_r};
  assign dist_w = sum_w[64] ? '1 : sum_w[63:0];
  assign hit_w  = pb_v_r && pb_el_r && (dist_w <= best_d_r);

  assign lane_start = (state_r == S_LAT);

  lnaa_mean_lane u_lane_x (
    .clk(clk), .rst_n(rst_n), .start(lane_start),
    .old_val({rd_ent.x[31], rd_ent.x}), .obs_val({cur_r.point_x[31], cur_r.point_x}),
    .prev(rd_ent.count), .done(lane_done[0]), .mean(qx)
  );
  lnaa_mean_lane u_lane_y (
    .clk(clk), .rst_n(rst_n), .start(lane_start),
    .old_val({rd_ent.y[31], rd_ent.y}), .obs_val({cur_r.point_y[31], cur_r.point_y}),
    .prev(rd_ent.count), .done(lane_done[1]), .mean(qy)
  );
  lnaa_mean_lane u_lane_z (
    .clk(clk), .rst_n(rst_n), .start(lane_start),
    .old_val({rd_ent.z[31], rd_ent.z}), .obs_val({cur_r.point_z[31], cur_r.point_z}),
    .prev(rd_ent.count), .done(lane_done[2]), .mean(qz)
  );
  lnaa_mean_lane u_lane_s (
    .clk(clk), .rst_n(rst_n), .start(lane_start),
    .old_val({17'd0, rd_ent.score}), .obs_val({17'd0, cur_r.score}),
    .prev(rd_ent.count), .done(lane_done[3]), .mean(qs)
  );

  always_comb begin
    new_ent            = ent_r;
    new_ent.matched    = cur_r.box_points;
    new_ent.inliers    = cur_r.fit_points;
    new_ent.last_time  = cur_r.obs_time;
    if (best_v_r) begin
      new_ent.x     = qx;
      new_ent.y     = qy;
      new_ent.z     = qz;
      new_ent.score = qs[15:0];
      new_ent.count = (ent_r.count == 16'hFFFF) ? 16'hFFFF : ent_r.count + 16'd1;
      reached_w     = {1'b0, ent_r.count} + 17'd1;
    end else begin
      new_ent.label      = cur_r.label;
      new_ent.x          = cur_r.point_x;
      new_ent.y          = cur_r.point_y;
      new_ent.z          = cur_r.point_z;
      new_ent.score      = cur_r.score;
      new_ent.count      = 16'd1;
      new_ent.first_time = cur_r.obs_time;
      new_ent.id         = next_id_r;
      reached_w          = 17'd1;
    end
    res_w.landmark_id  = new_ent.id;
    res_w.created      = !best_v_r;
    res_w.dropped_full = 1'b0;
    res_w.obs_count    = new_ent.count;
    res_w.confirmed    = (cfg.confirm_count != 16'd0) &&
                         (reached_w == {1'b0, cfg.confirm_count});
    res_w.mean_x       = new_ent.x;
    res_w.mean_y       = new_ent.y;
    res_w.mean_z       = new_ent.z;
    res_w.avg_score    = new_ent.score;
    res_w.revision     = rev_r + 32'd1;
    drop_w              = '0;
    drop_w.dropped_full = 1'b1;
    drop_w.revision     = rev_r;
  end

  assign we    = (state_r == S_WR);
  assign waddr = best_v_r ? best_r : free_r;
  assign q_pop = (state_r == S_IDLE) && !q_empty;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (!q_empty) state_nxt = S_RAD;
      S_RAD:  state_nxt = S_SCAN;
      S_SCAN: begin
        if (scan_end) begin
          if (best_v_r) state_nxt = S_RDB;
          else if (free_v_r) state_nxt = S_WR;
          else state_nxt = S_OUT;
        end
      end
      S_RDB:  state_nxt = S_LAT;
      S_LAT:  state_nxt = S_DIV;
      S_DIV:  if (&lane_done) state_nxt = S_WR;
      S_WR:   state_nxt = S_OUT;
      S_OUT:  if (!out_valid_r) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      next_id_r   <= 32'd1;
      rev_r       <= '0;
      best_v_r    <= 1'b0;
      free_v_r    <= 1'b0;
      issue_r     <= '0;
      p1_v_r      <= 1'b0;
      pa_v_r      <= 1'b0;
      pb_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      p1_v_r  <= issue_w;
      pa_v_r  <= p1_v_r;
      pb_v_r  <= pa_v_r;
      if (issue_w) begin
        issue_r <= issue_r + 1'b1;
      end
      if (state_r == S_RAD) begin
        issue_r  <= '0;
        best_v_r <= 1'b0;
        free_v_r <= 1'b0;
      end
      if (p1_v_r && !valid_r[p1_idx_r] && !free_v_r) begin
        free_v_r <= 1'b1;
      end
      if (hit_w) begin
        best_v_r <= 1'b1;
      end
      if (state_r == S_WR) begin
        rev_r <= rev_r + 32'd1;
        if (!best_v_r) begin
          valid_r[free_r] <= 1'b1;
          next_id_r       <= next_id_r + 32'd1;
        end
      end
      if (out_pop && out_valid_r) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == S_OUT && !out_valid_r) begin
        out_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_item;
    end
    if (state_r == S_RAD) begin
      best_d_r <= 64'(cfg.merge_radius * cfg.merge_radius);
    end
    p1_idx_r <= issue_r[IW-1:0];
    pa_idx_r <= p1_idx_r;
    pa_el_r  <= el_w;
    pa_ax_r  <= dx_w[32] ? ndx_w[31:0] : dx_w[31:0];
    pa_ay_r  <= dy_w[32] ? ndy_w[31:0] : dy_w[31:0];
    pb_idx_r <= pa_idx_r;
    pb_el_r  <= pa_el_r;
    pb_sx_r  <= pa_ax_r * pa_ax_r;
    pb_sy_r  <= pa_ay_r * pa_ay_r;
    if (p1_v_r && !valid_r[p1_idx_r] && !free_v_r) begin
      free_r <= p1_idx_r;
    end
    if (hit_w) begin
      best_d_r <= dist_w;
      best_r   <= pb_idx_r;
    end
    if (state_r == S_LAT) begin
      ent_r <= rd_ent;
    end
    if (state_r == S_WR) begin
      res_r <= res_w;
    end else if (scan_end && !best_v_r && !free_v_r) begin
      res_r <= drop_w;
    end
    if (state_r == S_OUT && !out_valid_r) begin
      out_item <= res_r;
    end
  end

  assign out_empty = !out_valid_r;

  `LNAA_ASSERT_IMP(a_lanes_done, (state_r == S_WR) && best_v_r, &lane_done, "write before mean done")
  `LNAA_ASSERT_IMP(a_best_valid, best_v_r, valid_r[best_r], "match on empty slot")
  `LNAA_ASSERT_IMP(a_free_empty, (state_r == S_SCAN) && free_v_r, !valid_r[free_r], "free slot in use")
  `LNAA_ASSERT_NXT(a_rev_hold, state_r != S_WR, $stable(rev_r), "revision moved without write")
endmodule
`default_nettype wire

// File: design/landmark_nearest_associate_average_unit.sv
// Top level of the landmark nearest-neighbor association and running-mean unit.
// One item at a time is taken from a two-deep input queue. The back end scans
// all MAX_LANDMARKS table slots through one RAM read port, one slot a cycle
// into a three-stage distance pipeline. A match then reads the entry and runs
// four bit-serial dividers in parallel; a creation or a drop skips them. A new
// result enters the output register only once the previous one has been popped.
// Results wait in one output register while the next item is already queued.
`default_nettype none
module landmark_nearest_associate_average_unit
  import lnaa_pkg::*;
#(
  parameter int MAX_LANDMARKS = 64
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_push,
  output logic                      in_full,
  input  wire in_item_t             in_item,
  output logic                      out_empty,
  input  wire logic                 out_pop,
  output out_item_t                 out_item,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]          cfg_data
);
  cfg_t     cfg_r;
  logic     q_pop, q_empty;
  in_item_t q_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.merge_radius  <= MERGE_RADIUS_RST;
      cfg_r.confirm_count <= MIN_OBS_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MERGE_RADIUS: cfg_r.merge_radius <= cfg_data[30:0];
        CFG_MIN_OBS:      cfg_r.confirm_count <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  lnaa_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_item (in_item),
    .q_pop   (q_pop),
    .q_empty (q_empty),
    .q_item  (q_item)
  );

  lnaa_back #(.MAX_LANDMARKS(MAX_LANDMARKS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_pop     (q_pop),
    .q_empty   (q_empty),
    .q_item    (q_item),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_item  (out_item)
  );
endmodule
`default_nettype wire

// File: tb/sv/landmark_association_checker.sv
// Checker for the landmark association unit: predicts each result and compares.
`default_nettype none
module landmark_association_checker
  import lnaa_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_push,
  input  wire logic                 in_full,
  input  wire in_item_t             in_item,
  input  wire logic                 out_empty,
  input  wire logic                 out_pop,
  input  wire out_item_t            out_item,
  input  wire logic                 cfg_valid,
  input  wire logic                 cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]          cfg_data,
  output int                        errors,
  output int                        pending
);

  localparam int SLOTS = 64;

  logic [30:0]        radius;
  logic [15:0]        min_obs;
  logic               tab_valid [SLOTS];
  logic               tab_label [SLOTS];
  logic signed [31:0] tab_x [SLOTS];
  logic signed [31:0] tab_y [SLOTS];
  logic signed [31:0] tab_z [SLOTS];
  logic [15:0]        tab_score [SLOTS];
  logic [15:0]        tab_count [SLOTS];
  logic [31:0]        tab_id [SLOTS];
  logic [31:0]        next_id;
  logic [31:0]        revision;
  out_item_t          expected_q [$];

  function automatic logic [64:0] square_mag(logic signed [31:0] a, logic signed [31:0] b);
    logic signed [32:0] d;
    logic [64:0]        m;
    d = $signed({a[31], a}) - $signed({b[31], b});
    m = (d < 0) ? 65'(-d) : 65'(d);
    return m * m;
  endfunction

  function automatic logic signed [31:0] mean_step(logic signed [31:0] old,
                                                   logic signed [31:0] obs,
                                                   longint prev);
    longint num;
    num = longint'(old) * prev + longint'(obs);
    return 32'(num / (prev + 1));
  endfunction

  function automatic out_item_t associate(in_item_t it);
    out_item_t  r;
    logic [64:0] best;
    logic [64:0] d2;
    int          slot;
    longint      prev;
    longint      reached;
    best = 65'(radius) * 65'(radius);
    slot = -1;
    r = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (tab_valid[i] && tab_label[i] == it.label) begin
        d2 = square_mag(tab_x[i], it.point_x) + square_mag(tab_y[i], it.point_y);
        if (d2[64]) d2 = {1'b0, {64{1'b1}}};
        if (d2 <= best) begin
          best = d2;
          slot = i;
        end
      end
    end
    if (slot >= 0) begin
      prev = longint'(tab_count[slot]);
      tab_x[slot] = mean_step(tab_x[slot], it.point_x, prev);
      tab_y[slot] = mean_step(tab_y[slot], it.point_y, prev);
      tab_z[slot] = mean_step(tab_z[slot], it.point_z, prev);
      tab_score[slot] = 16'((longint'(tab_score[slot]) * prev + longint'(it.score)) / (prev + 1));
      reached = prev + 1;
      if (prev < 65535) tab_count[slot] = 16'(prev + 1);
    end else begin
      for (int i = SLOTS - 1; i >= 0; i--) begin
        if (!tab_valid[i]) slot = i;
      end
      if (slot < 0) begin
        r.dropped_full = 1'b1;
        r.revision = revision;
        return r;
      end
      r.created = 1'b1;
      tab_valid[slot] = 1'b1;
      tab_label[slot] = it.label;
      tab_id[slot] = next_id;
      next_id = next_id + 1;
      tab_x[slot] = it.point_x;
      tab_y[slot] = it.point_y;
      tab_z[slot] = it.point_z;
      tab_score[slot] = it.score;
      tab_count[slot] = 16'd1;
      reached = 1;
    end
    revision = revision + 1;
    r.landmark_id = tab_id[slot];
    r.obs_count = tab_count[slot];
    r.confirmed = (min_obs != 0) && (reached == longint'(min_obs));
    r.mean_x = tab_x[slot];
    r.mean_y = tab_y[slot];
    r.mean_z = tab_z[slot];
    r.avg_score = tab_score[slot];
    r.revision = revision;
    return r;
  endfunction

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] got_v);
    if (exp_v !== got_v) begin
      errors++;
      if (errors <= 10)
        $display("mismatch %s: expected %h, got %h", name, exp_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    out_item_t e;
    if (!rst_n) begin
      radius = MERGE_RADIUS_RST;
      min_obs = MIN_OBS_RST;
      for (int i = 0; i < SLOTS; i++) tab_valid[i] = 1'b0;
      next_id = 32'd1;
      revision = '0;
      expected_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MERGE_RADIUS: radius = cfg_data[30:0];
          CFG_MIN_OBS:      min_obs = cfg_data[15:0];
          default: ;
        endcase
      end
      if (in_push && !in_full) expected_q.insert(expected_q.size(), associate(in_item));
      if (out_pop && !out_empty) begin
        if (expected_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected item: %p", out_item);
        end else begin
          e = expected_q.pop_front();
          check_field("landmark_id", e.landmark_id, out_item.landmark_id);
          check_field("created", e.created, out_item.created);
          check_field("dropped_full", e.dropped_full, out_item.dropped_full);
          check_field("obs_count", e.obs_count, out_item.obs_count);
          check_field("confirmed", e.confirmed, out_item.confirmed);
          check_field("mean_x", e.mean_x, out_item.mean_x);
          check_field("mean_y", e.mean_y, out_item.mean_y);
          check_field("mean_z", e.mean_z, out_item.mean_z);
          check_field("avg_score", e.avg_score, out_item.avg_score);
          check_field("revision", e.revision, out_item.revision);
        end
      end
    end
    pending <= expected_q.size();
  end

endmodule
`default_nettype wire

// File: tb/sv/tb_landmark_nearest_associate_average_unit.sv
// Testbench top: drives observations and configuration, gives the verdict.
`default_nettype none
module tb_landmark_nearest_associate_average_unit;
  import lnaa_pkg::*;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_push = 1'b0;
  logic                 in_full;
  in_item_t             in_item = '0;
  logic                 out_empty;
  logic                 out_pop = 1'b0;
  out_item_t            out_item;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_MERGE_RADIUS;
  logic [31:0]          cfg_data = '0;
  int                   errors;
  int                   pending;
  bit                   gaps_on = 1'b1;
  int                   pop_hold = 0;
  logic [30:0]          cur_radius;
  logic signed [31:0]   spot_x [$];
  logic signed [31:0]   spot_y [$];
  logic                 spot_label [$];

  landmark_nearest_associate_average_unit dut (.*);

  landmark_association_checker checker_i (.*);

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (pop_hold > 0) begin
      pop_hold--;
      out_pop <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 5) == 0) begin
      pop_hold = $urandom_range(0, 4);
      out_pop <= 1'b0;
    end else begin
      out_pop <= 1'b1;
    end
  end

  task automatic wait_drained();
    in_push <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_cfg(logic [30:0] radius, logic [15:0] min_obs);
    wait_drained();
    cur_radius = radius;
    cfg_valid <= 1'b1;
    cfg_index <= CFG_MERGE_RADIUS;
    cfg_data <= {1'b0, radius};
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_MIN_OBS;
    cfg_data <= {16'd0, min_obs};
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic send(in_item_t it);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_push <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_full);
  endtask

  function automatic in_item_t obs(logic lab, logic signed [31:0] x, logic signed [31:0] y);
    in_item_t it;
    it.label = lab;
    it.point_x = x;
    it.point_y = y;
    it.point_z = $urandom;
    it.score = 16'($urandom);
    it.box_points = 16'($urandom);
    it.fit_points = 16'($urandom);
    it.obs_time = 48'({$urandom, $urandom});
    return it;
  endfunction

  function automatic logic signed [31:0] jitter(logic signed [31:0] v);
    longint r;
    r = (cur_radius > 31'd1048576) ? 1048576 : longint'(cur_radius);
    return v + 32'(longint'($urandom_range(0, 32'(2 * r))) - r);
  endfunction

  task automatic random_item();
    in_item_t it;
    int       k;
    int       pick;
    pick = $urandom_range(0, 99);
    if (pick < 70 && spot_x.size() > 0) begin
      k = $urandom_range(0, spot_x.size() - 1);
      it = obs(spot_label[k], jitter(spot_x[k]), jitter(spot_y[k]));
    end else begin
      it = obs(1'($urandom_range(0, 1)), $urandom, $urandom);
      if (pick < 85) begin
        spot_x.insert(spot_x.size(), it.point_x);
        spot_y.insert(spot_y.size(), it.point_y);
        spot_label.insert(spot_label.size(), it.label);
      end
    end
    send(it);
  endtask

  initial begin
    in_item_t it;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // overflowing distances, field extremes, creation confirms at threshold one
    write_cfg(31'h7FFF_FFFF, 16'd1);
    it = '0;
    it.point_x = 32'sh8000_0000;
    it.point_y = 32'sh8000_0000;
    send(it);
    it = '1;
    it.label = 1'b0;
    it.point_x = 32'sh7FFF_FFFF;
    it.point_y = 32'sh7FFF_FFFF;
    it.point_z = 32'sh8000_0000;
    send(it);
    it.point_x = 32'sh8000_0000;
    it.point_y = 32'sh8000_0000;
    it.point_z = 32'sh7FFF_FFFF;
    send(it);
    send(obs(1'b1, 0, 0));
    send(obs(1'b1, -5, 3));
    send(obs(1'b1, 32'sh7FFF_FFFF, 32'sh8000_0000));

    // tie on equal distance, threshold zero
    write_cfg(31'd1000, 16'd0);
    send(obs(1'b1, 1000, 32'sh0100_0000));
    send(obs(1'b1, -1000, 32'sh0100_0000));
    send(obs(1'b1, 0, 32'sh0100_0000));
    send(obs(1'b0, 32'sh8000_0000, 32'sh8000_0000));

    // zero radius: only exact positions merge
    write_cfg(31'd0, 16'd65535);
    send(obs(1'b0, 77, 88));
    send(obs(1'b0, 77, 88));
    send(obs(1'b0, 78, 88));
    send(obs(1'b1, 77, 88));

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: write_cfg(31'd19661, 16'd3);
        1: write_cfg(31'd1048576, 16'd65535);
        2: write_cfg(31'd500, 16'd2);
        3: write_cfg(31'h7FFF_FFFF, 16'd1);
        default: begin
          write_cfg(31'd65536, 16'd4);
          gaps_on = 1'b0;
        end
      endcase
      for (int n = 0; n < 220; n++) random_item();
    end
    wait_drained();
    if (errors == 0 && pending == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  initial begin
    #(8 * 1500000);
    $display("simulation failed");
    $finish;
  end

endmodule
`default_nettype wire
